[hw/rtl/kcl_pkg.sv]
// ----------------------------------------------------------------------------
// kcl_pkg
// Shared widths, codes and types of the keypad code lock controller
// ----------------------------------------------------------------------------
package kcl_pkg;

   localparam int unsigned CODE_LENGTH_DEF = 6;
   localparam int unsigned SLOT_COUNT      = 20;

   localparam int unsigned OP_W     = 2;
   localparam int unsigned KEY_W    = 4;
   localparam int unsigned STATUS_W = 4;
   localparam int unsigned SLOT_W   = 5;
   localparam int unsigned LEN_W    = 3;
   localparam int unsigned ERR_W    = 8;
   localparam int unsigned MODE_W   = 3;

   localparam logic [KEY_W-1:0] KEY_STAR = 4'd14;
   localparam logic [KEY_W-1:0] KEY_HASH = 4'd15;
   localparam logic [KEY_W-1:0] KEY_ONE  = 4'd1;
   localparam logic [KEY_W-1:0] KEY_NINE = 4'd9;

   localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(SLOT_COUNT - 1);
   localparam logic [SLOT_W-1:0] SLOT_TEN  = 5'd10;
   localparam logic [ERR_W-1:0]  ERR_MAX   = 8'hFF;

   typedef enum logic [OP_W-1:0] {
      OP_KEY    = 2'd0,
      OP_ENROLL = 2'd1,
      OP_DELETE = 2'd2,
      OP_UNUSED = 2'd3
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_TAKEN    = 4'd0,
      ST_MATCH    = 4'd1,
      ST_MISMATCH = 4'd2,
      ST_CANCEL   = 4'd3,
      ST_NEW      = 4'd4,
      ST_CONF_BAD = 4'd5,
      ST_CONF_OK  = 4'd6,
      ST_STORED   = 4'd7,
      ST_CLEARED  = 4'd8,
      ST_IGNORED  = 4'd9
   } status_type;

   typedef enum logic [MODE_W-1:0] {
      MODE_VERIFY    = 3'd0,
      MODE_NEW       = 3'd1,
      MODE_CONFIRM   = 3'd2,
      MODE_ENROLL_ID = 3'd3,
      MODE_DELETE_ID = 3'd4
   } mode_type;

endpackage

[hw/rtl/kcl_if.sv]
// ----------------------------------------------------------------------------
// kcl_req_if / kcl_rsp_if
// Valid/ready channels for keypad events and lock results
// ----------------------------------------------------------------------------
interface kcl_req_if
   import kcl_pkg::*;
();
   logic             valid;
   logic             ready;
   logic [OP_W-1:0]  operation;
   logic [KEY_W-1:0] key_code;

   modport source (output valid, output operation, output key_code, input ready);
   modport sink   (input valid, input operation, input key_code, output ready);
endinterface

interface kcl_rsp_if
   import kcl_pkg::*;
();
   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic [SLOT_W-1:0]   slot_index;
   logic [LEN_W-1:0]    entry_length;
   logic [ERR_W-1:0]    error_total;
   logic [MODE_W-1:0]   mode_now;

   modport source (output valid, output status, output slot_index, output entry_length,
                   output error_total, output mode_now, input ready);
   modport sink   (input valid, input status, input slot_index, input entry_length,
                   input error_total, input mode_now, output ready);
endinterface

[hw/rtl/keypad_code_lock_controller_unit.sv]
// ----------------------------------------------------------------------------
// keypad_code_lock_controller_unit
// Keypad code lock: entry buffer, 20 stored code slots, enrollment, deletion
// ----------------------------------------------------------------------------
// Usage:
//   req_chan carries one keypad event or start command per item; rsp_chan
//   returns exactly one result item per request item, in order.
//   req_chan.ready is high only while the sequencer is idle; one item at a
//   time is worked on.
//   Most items pass through an execute step and a deliver step on their
//   way from acceptance to the result register.
//   The key that completes a code in verify mode starts a scan of the code
//   memory through one equality comparator, one slot per cycle with a
//   registered read; the scan runs through the last slot on a miss and
//   ends early on a match.
//   The result register lets the next item be accepted while a result waits;
//   if the receiver stalls, the following item holds in its deliver step
//   until the result register frees up.
//   Synchronous reset returns to verify mode with an empty entry, all slot
//   marks cleared and a zero error count; the code memory is not cleared
//   and no clearing pass is needed.
// ----------------------------------------------------------------------------
module keypad_code_lock_controller_unit
   import kcl_pkg::*;
#(
   parameter int unsigned CODE_LENGTH = CODE_LENGTH_DEF
) (
   input  logic     clock,
   input  logic     reset,
   kcl_req_if.sink   req_chan,
   kcl_rsp_if.source rsp_chan
);

   localparam int unsigned BUF_W = KEY_W * CODE_LENGTH;
   localparam logic [LEN_W:0] CODE_LEN_C = (LEN_W + 1)'(CODE_LENGTH);

   typedef enum logic [3:0] {
      S_IDLE = 4'b0001,
      S_EXEC = 4'b0010,
      S_SCAN = 4'b0100,
      S_DONE = 4'b1000
   } state_type;

   state_type          state_ff, state_in;
   mode_type           mode_ff, mode_in;
   logic [BUF_W-1:0]   buf_ff, buf_in;
   logic [LEN_W-1:0]   cnt_ff, cnt_in;
   logic [BUF_W-1:0]   pending_ff, pending_in;
   logic [1:0]         id_ff, id_in;
   logic [SLOT_COUNT-1:0] valid_ff, valid_in;
   logic [ERR_W-1:0]   err_ff, err_in;

   op_type             op_ff, op_in;
   logic [KEY_W-1:0]   key_ff, key_in;
   logic [BUF_W-1:0]   code_ff, code_in;
   status_type         status_ff, status_in;
   logic [SLOT_W-1:0]  slot_ff, slot_in;

   logic [SLOT_W-1:0]  idx_ff, idx_in;
   logic [SLOT_W-1:0]  cmp_idx_ff, cmp_idx_in;
   logic               live_ff, live_in;
   logic               last_ff, last_in;
   logic [BUF_W-1:0]   rd_data_ff;
   logic [BUF_W-1:0]   code_mem [SLOT_COUNT];

   logic               mem_we;
   logic [SLOT_W-1:0]  id_val;
   logic [BUF_W-1:0]   app_buf;
   logic [LEN_W:0]     cnt_plus;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic [SLOT_W-1:0]   rsp_slot_ff, rsp_slot_in;
   logic [LEN_W-1:0]    rsp_len_ff, rsp_len_in;
   logic [ERR_W-1:0]    rsp_err_ff, rsp_err_in;
   logic [MODE_W-1:0]   rsp_mode_ff, rsp_mode_in;

   assign req_chan.ready = (state_ff == S_IDLE);

   assign app_buf  = (buf_ff << KEY_W) | BUF_W'(key_ff);
   assign cnt_plus = {1'b0, cnt_ff} + (LEN_W + 1)'(1);
   assign id_val   = id_ff[0] ? (SLOT_W'(key_ff) + SLOT_TEN) : SLOT_W'(key_ff);

   always_comb begin
      state_in     = state_ff;
      mode_in      = mode_ff;
      buf_in       = buf_ff;
      cnt_in       = cnt_ff;
      pending_in   = pending_ff;
      id_in        = id_ff;
      valid_in     = valid_ff;
      err_in       = err_ff;
      op_in        = op_ff;
      key_in       = key_ff;
      code_in      = code_ff;
      status_in    = status_ff;
      slot_in      = slot_ff;
      idx_in       = idx_ff;
      cmp_idx_in   = cmp_idx_ff;
      live_in      = live_ff;
      last_in      = last_ff;
      mem_we       = 1'b0;
      rsp_valid_in  = rsp_valid_ff && !rsp_chan.ready;
      rsp_status_in = rsp_status_ff;
      rsp_slot_in   = rsp_slot_ff;
      rsp_len_in    = rsp_len_ff;
      rsp_err_in    = rsp_err_ff;
      rsp_mode_in   = rsp_mode_ff;

      case (state_ff)
         S_IDLE: begin
            if (req_chan.valid) begin
               op_in    = op_type'(req_chan.operation);
               key_in   = req_chan.key_code;
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            state_in  = S_DONE;
            status_in = ST_TAKEN;
            slot_in   = '0;
            if (op_ff inside {OP_ENROLL, OP_DELETE}) begin
               buf_in  = '0;
               cnt_in  = '0;
               id_in   = '0;
               mode_in = (op_ff == OP_ENROLL) ? MODE_NEW : MODE_DELETE_ID;
            end else if (op_ff == OP_UNUSED) begin
               status_in = ST_IGNORED;
            end else if (mode_ff inside {MODE_ENROLL_ID, MODE_DELETE_ID}) begin
               if (!id_ff[1]) begin
                  if (key_ff > KEY_ONE) begin
                     status_in = ST_IGNORED;
                  end else begin
                     id_in = {1'b1, key_ff[0]};
                  end
               end else if (key_ff > KEY_NINE) begin
                  status_in = ST_IGNORED;
               end else begin
                  id_in   = '0;
                  slot_in = id_val;
                  mode_in = MODE_VERIFY;
                  if (mode_ff == MODE_ENROLL_ID) begin
                     mem_we    = 1'b1;
                     valid_in  = valid_ff | (SLOT_COUNT'(1) << id_val);
                     status_in = ST_STORED;
                  end else begin
                     valid_in  = valid_ff & ~(SLOT_COUNT'(1) << id_val);
                     status_in = ST_CLEARED;
                  end
               end
            end else if (mode_ff inside {MODE_VERIFY, MODE_NEW, MODE_CONFIRM}) begin
               if (key_ff == KEY_HASH) begin
                  buf_in = '0;
                  cnt_in = '0;
                  if (mode_ff == MODE_CONFIRM) begin
                     mode_in   = MODE_NEW;
                     status_in = ST_CONF_BAD;
                  end else begin
                     mode_in   = MODE_VERIFY;
                     status_in = ST_CANCEL;
                  end
               end else if (key_ff == KEY_STAR) begin
                  if (cnt_ff != '0) begin
                     cnt_in = cnt_ff - LEN_W'(1);
                     buf_in = buf_ff >> KEY_W;
                  end
               end else if (cnt_plus >= CODE_LEN_C) begin
                  buf_in = '0;
                  cnt_in = '0;
                  case (mode_ff)
                     MODE_VERIFY: begin
                        code_in  = app_buf;
                        idx_in   = '0;
                        live_in  = 1'b0;
                        last_in  = 1'b0;
                        state_in = S_SCAN;
                     end
                     MODE_NEW: begin
                        pending_in = app_buf;
                        mode_in    = MODE_CONFIRM;
                        status_in  = ST_NEW;
                     end
                     default: begin
                        if (app_buf == pending_ff) begin
                           mode_in   = MODE_ENROLL_ID;
                           id_in     = '0;
                           status_in = ST_CONF_OK;
                        end else begin
                           mode_in   = MODE_NEW;
                           status_in = ST_CONF_BAD;
                        end
                     end
                  endcase
               end else begin
                  buf_in = app_buf;
                  cnt_in = cnt_plus[LEN_W-1:0];
               end
            end else begin
               status_in = ST_IGNORED;
            end
         end
         S_SCAN: begin
            // issue stage: read slot idx, compare stage: check previous slot
            live_in    = valid_ff[idx_ff];
            last_in    = (idx_ff == SLOT_LAST);
            cmp_idx_in = idx_ff;
            idx_in     = (idx_ff == SLOT_LAST) ? idx_ff : idx_ff + SLOT_W'(1);
            if (live_ff && rd_data_ff == code_ff) begin
               status_in = ST_MATCH;
               slot_in   = cmp_idx_ff;
               state_in  = S_DONE;
            end else if (last_ff) begin
               status_in = ST_MISMATCH;
               slot_in   = '0;
               err_in    = (err_ff == ERR_MAX) ? err_ff : err_ff + ERR_W'(1);
               state_in  = S_DONE;
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = status_ff;
               rsp_slot_in   = slot_ff;
               rsp_len_in    = cnt_ff;
               rsp_err_in    = err_ff;
               rsp_mode_in   = mode_ff;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         mode_ff      <= MODE_VERIFY;
         buf_ff       <= '0;
         cnt_ff       <= '0;
         pending_ff   <= '0;
         id_ff        <= '0;
         valid_ff     <= '0;
         err_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         mode_ff      <= mode_in;
         buf_ff       <= buf_in;
         cnt_ff       <= cnt_in;
         pending_ff   <= pending_in;
         id_ff        <= id_in;
         valid_ff     <= valid_in;
         err_ff       <= err_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      key_ff        <= key_in;
      code_ff       <= code_in;
      status_ff     <= status_in;
      slot_ff       <= slot_in;
      idx_ff        <= idx_in;
      cmp_idx_ff    <= cmp_idx_in;
      live_ff       <= live_in;
      last_ff       <= last_in;
      rsp_status_ff <= rsp_status_in;
      rsp_slot_ff   <= rsp_slot_in;
      rsp_len_ff    <= rsp_len_in;
      rsp_err_ff    <= rsp_err_in;
      rsp_mode_ff   <= rsp_mode_in;
   end

   // code memory, registered read
   always_ff @(posedge clock) begin
      if (mem_we) begin
         code_mem[id_val] <= pending_ff;
      end
      rd_data_ff <= code_mem[idx_ff];
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.status       = rsp_status_ff;
   assign rsp_chan.slot_index   = rsp_slot_ff;
   assign rsp_chan.entry_length = rsp_len_ff;
   assign rsp_chan.error_total  = rsp_err_ff;
   assign rsp_chan.mode_now     = rsp_mode_ff;

`ifndef SYNTHESIS
   a_cnt_below_len: assert property (@(posedge clock) disable iff (reset)
      {1'b0, cnt_ff} < CODE_LEN_C)
      else $error("entry count reached code length");

   a_scan_in_verify: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_SCAN |-> mode_ff == MODE_VERIFY && cnt_ff == '0)
      else $error("scan outside verify mode or with held entry");

   a_err_monotonic: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> err_ff >= $past(err_ff))
      else $error("error count decreased");

   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_DONE))
      else $error("result raised outside deliver step");
`endif

endmodule

[tb/sv/tb_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the keypad code lock controller
// ----------------------------------------------------------------------------
// A short table of keypad events runs first, some rows carrying a typed-in
// result. Random enroll, verify, delete, broken and noise sequences follow in
// four handshake pressure phases, then a short mixed tail. Every result is
// compared field by field with the typed-in result if its row has one, else
// with an in-bench lock model tracking mode, entry, pending code and slots.
// ----------------------------------------------------------------------------
module tb_top;
   import kcl_pkg::*;

   localparam int unsigned CODE_W      = CODE_LENGTH_DEF * KEY_W;
   localparam int          PHASE_ITEMS = 290;
   localparam int          CYCLE_LIMIT = 800000;
   localparam int          DIR_N       = 25;

   typedef struct packed {
      status_type        status;
      logic [SLOT_W-1:0] slot;
      logic [LEN_W-1:0]  len;
      logic [ERR_W-1:0]  err;
      mode_type          mode;
   } lock_result_t;

   typedef struct packed {
      op_type           op;
      logic [KEY_W-1:0] key;
      bit               typed;
      lock_result_t     res;
   } key_row_t;

   logic clock = 1'b0;
   logic reset = 1'b1;

   kcl_req_if req_chan ();
   kcl_rsp_if rsp_chan ();

   keypad_code_lock_controller_unit i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   // lock model state
   mode_type                cur_mode;
   logic [CODE_W-1:0]       entry_sym;
   logic [LEN_W-1:0]        entry_cnt;
   logic [CODE_W-1:0]       pending_sym;
   logic [1:0]              id_digit;
   logic [CODE_W-1:0]       slot_code [SLOT_COUNT];
   logic [SLOT_COUNT-1:0]   slot_mark;
   logic [ERR_W-1:0]        fail_cnt;

   lock_result_t lock_results_due [$];
   key_row_t     key_rows [DIR_N];

   int gap_pct   = 0;
   int stall_pct = 0;
   int n_items   = 0;
   int n_counted = 0;
   int n_checked = 0;
   int n_fail    = 0;
   int cycle_cnt = 0;
   int status_hits [16];

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   function automatic lock_result_t lock_predict(op_type op, logic [KEY_W-1:0] key);
      lock_result_t      res;
      logic [CODE_W-1:0] code;
      bit                found;
      res.status = ST_TAKEN;
      res.slot   = '0;
      found      = 1'b0;
      case (op)
         OP_ENROLL, OP_DELETE: begin
            entry_sym = '0;
            entry_cnt = '0;
            id_digit  = '0;
            cur_mode  = (op == OP_ENROLL) ? MODE_NEW : MODE_DELETE_ID;
         end
         OP_UNUSED: begin
            res.status = ST_IGNORED;
         end
         default: begin
            if (cur_mode == MODE_ENROLL_ID || cur_mode == MODE_DELETE_ID) begin
               if (!id_digit[1]) begin
                  if (key > KEY_ONE) res.status = ST_IGNORED;
                  else id_digit = {1'b1, key[0]};
               end else if (key > KEY_NINE) begin
                  res.status = ST_IGNORED;
               end else begin
                  res.slot = id_digit[0] ? SLOT_TEN + SLOT_W'(key) : SLOT_W'(key);
                  id_digit = '0;
                  if (cur_mode == MODE_ENROLL_ID) begin
                     slot_code[res.slot] = pending_sym;
                     slot_mark[res.slot] = 1'b1;
                     res.status = ST_STORED;
                  end else begin
                     slot_mark[res.slot] = 1'b0;
                     res.status = ST_CLEARED;
                  end
                  cur_mode = MODE_VERIFY;
               end
            end else if (key == KEY_HASH) begin
               entry_sym = '0;
               entry_cnt = '0;
               if (cur_mode == MODE_CONFIRM) begin
                  cur_mode   = MODE_NEW;
                  res.status = ST_CONF_BAD;
               end else begin
                  cur_mode   = MODE_VERIFY;
                  res.status = ST_CANCEL;
               end
            end else if (key == KEY_STAR) begin
               if (entry_cnt != 0) begin
                  entry_cnt = entry_cnt - 1'b1;
                  entry_sym = entry_sym >> KEY_W;
               end
            end else begin
               entry_sym = {entry_sym[CODE_W-KEY_W-1:0], key};
               entry_cnt = entry_cnt + 1'b1;
               if (entry_cnt == CODE_LENGTH_DEF) begin
                  code      = entry_sym;
                  entry_sym = '0;
                  entry_cnt = '0;
                  case (cur_mode)
                     MODE_VERIFY: begin
                        for (int i = 0; i < SLOT_COUNT; i++) begin
                           if (!found && slot_mark[i] && slot_code[i] == code) begin
                              found    = 1'b1;
                              res.slot = SLOT_W'(i);
                           end
                        end
                        if (found) begin
                           res.status = ST_MATCH;
                        end else begin
                           res.status = ST_MISMATCH;
                           if (fail_cnt != ERR_MAX) fail_cnt = fail_cnt + 1'b1;
                        end
                     end
                     MODE_NEW: begin
                        pending_sym = code;
                        cur_mode    = MODE_CONFIRM;
                        res.status  = ST_NEW;
                     end
                     default: begin
                        if (code == pending_sym) begin
                           cur_mode   = MODE_ENROLL_ID;
                           id_digit   = '0;
                           res.status = ST_CONF_OK;
                        end else begin
                           cur_mode   = MODE_NEW;
                           res.status = ST_CONF_BAD;
                        end
                     end
                  endcase
               end
            end
         end
      endcase
      res.len  = entry_cnt;
      res.err  = fail_cnt;
      res.mode = cur_mode;
      return res;
   endfunction

   task automatic report_mismatch(string what, int got, int want);
      $display("tb: mismatch in %s at result %0d: got %0d, expected %0d",
               what, n_checked, got, want);
      n_fail++;
   endtask

   task automatic send(input op_type op, input logic [KEY_W-1:0] key,
                       input bit typed = 1'b0, input lock_result_t typed_res = '0);
      lock_result_t res;
      if (gap_pct != 0 && $urandom_range(99) < gap_pct) begin
         req_chan.valid <= 1'b0;
         repeat ($urandom_range(4, 1)) @(negedge clock);
      end
      req_chan.valid     <= 1'b1;
      req_chan.operation <= op;
      req_chan.key_code  <= key;
      @(posedge clock);
      while (req_chan.ready !== 1'b1) @(posedge clock);
      res = lock_predict(op, key);
      status_hits[res.status]++;
      if (res.status != ST_IGNORED) n_counted++;
      if (typed) res = typed_res;
      lock_results_due.push_back(res);
      n_items++;
      @(negedge clock);
   endtask

   function automatic logic [CODE_W-1:0] rand_code();
      logic [CODE_W-1:0] code;
      for (int i = 0; i < CODE_LENGTH_DEF; i++)
         code[i*KEY_W +: KEY_W] = KEY_W'($urandom_range(13));
      return code;
   endfunction

   // a stored code with the given chance, else a fresh one
   function automatic logic [CODE_W-1:0] code_pick(int pct);
      int idx;
      if (slot_mark == '0 || $urandom_range(99) >= pct) return rand_code();
      idx = $urandom_range(SLOT_COUNT - 1);
      while (!slot_mark[idx]) idx = (idx + 1) % SLOT_COUNT;
      return slot_code[idx];
   endfunction

   task automatic enter_code(input logic [CODE_W-1:0] code);
      int               edit_at;
      logic [KEY_W-1:0] sym;
      edit_at = ($urandom_range(9) == 0) ? $urandom_range(CODE_LENGTH_DEF - 2) : -1;
      for (int i = 0; i < CODE_LENGTH_DEF; i++) begin
         sym = code[(CODE_LENGTH_DEF-1-i)*KEY_W +: KEY_W];
         send(OP_KEY, sym);
         if (i == edit_at) begin
            send(OP_KEY, KEY_STAR);
            send(OP_KEY, sym);
         end
      end
   endtask

   task automatic enter_id();
      if ($urandom_range(4) == 0) send(OP_KEY, KEY_W'($urandom_range(15, 2)));
      send(OP_KEY, KEY_W'($urandom_range(1)));
      if ($urandom_range(4) == 0) send(OP_KEY, KEY_W'($urandom_range(15, 10)));
      send(OP_KEY, KEY_W'($urandom_range(9)));
   endtask

   task automatic run_flow();
      int                pick;
      int                sel;
      logic [CODE_W-1:0] code;
      pick = $urandom_range(99);
      if (pick < 35) begin
         enter_code(code_pick(60));
      end else if (pick < 60) begin
         send(OP_ENROLL, KEY_W'($urandom_range(15)));
         code = code_pick(30);
         enter_code(code);
         sel = $urandom_range(19);
         if (sel < 15) begin
            enter_code(code);
            enter_id();
         end else if (sel < 17) begin
            enter_code(code_pick(50));
         end else if (sel < 19) begin
            repeat ($urandom_range(5)) send(OP_KEY, KEY_W'($urandom_range(13)));
            send(OP_KEY, KEY_HASH);
         end
      end else if (pick < 72) begin
         send(OP_DELETE, KEY_W'($urandom_range(15)));
         enter_id();
      end else if (pick < 88) begin
         repeat ($urandom_range(5, 1)) send(OP_KEY, KEY_W'($urandom_range(14)));
         if ($urandom_range(1)) send(OP_KEY, KEY_HASH);
         else send(op_type'($urandom_range(2, 1)), KEY_W'($urandom_range(15)));
      end else begin
         repeat ($urandom_range(4, 1))
            send(op_type'($urandom_range(3)), KEY_W'($urandom_range(15)));
      end
   endtask

   task automatic drain();
      req_chan.valid <= 1'b0;
      do @(negedge clock); while (lock_results_due.size() != 0);
   endtask

   initial begin
      rsp_chan.ready <= 1'b0;
      forever begin
         @(negedge clock);
         rsp_chan.ready <= ($urandom_range(99) >= stall_pct);
      end
   end

   always @(posedge clock) begin
      cycle_cnt <= cycle_cnt + 1;
      if (cycle_cnt == CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding",
                  cycle_cnt, lock_results_due.size());
         $display("tb: failure");
         $finish;
      end
   end

   always @(posedge clock) begin
      lock_result_t want;
      if (!reset && rsp_chan.valid === 1'b1 && rsp_chan.ready === 1'b1) begin
         if (lock_results_due.size() == 0) begin
            report_mismatch("unexpected result, status", int'(rsp_chan.status), -1);
         end else begin
            want = lock_results_due.pop_front();
            if (rsp_chan.status !== want.status)
               report_mismatch("status", int'(rsp_chan.status), int'(want.status));
            if (rsp_chan.slot_index !== want.slot)
               report_mismatch("slot_index", int'(rsp_chan.slot_index), int'(want.slot));
            if (rsp_chan.entry_length !== want.len)
               report_mismatch("entry_length", int'(rsp_chan.entry_length), int'(want.len));
            if (rsp_chan.error_total !== want.err)
               report_mismatch("error_total", int'(rsp_chan.error_total), int'(want.err));
            if (rsp_chan.mode_now !== want.mode)
               report_mismatch("mode_now", int'(rsp_chan.mode_now), int'(want.mode));
         end
         n_checked++;
      end
   end

   initial begin
      int gap_tab   [4];
      int stall_tab [4];
      gap_tab   = '{0, 47, 0, 23};
      stall_tab = '{0, 0, 47, 23};
      key_rows = '{
         '{OP_KEY,    KEY_STAR, 1'b1, '{ST_TAKEN,    5'd0, 3'd0, 8'd0, MODE_VERIFY}},
         '{OP_KEY,    KEY_HASH, 1'b1, '{ST_CANCEL,   5'd0, 3'd0, 8'd0, MODE_VERIFY}},
         '{OP_UNUSED, KEY_HASH, 1'b1, '{ST_IGNORED,  5'd0, 3'd0, 8'd0, MODE_VERIFY}},
         '{OP_ENROLL, 4'd0,     1'b1, '{ST_TAKEN,    5'd0, 3'd0, 8'd0, MODE_NEW}},
         '{OP_KEY,    KEY_HASH, 1'b1, '{ST_CANCEL,   5'd0, 3'd0, 8'd0, MODE_VERIFY}},
         '{OP_ENROLL, KEY_HASH, 1'b1, '{ST_TAKEN,    5'd0, 3'd0, 8'd0, MODE_NEW}},
         '{OP_KEY,    4'd0,     1'b0, '0},
         '{OP_KEY,    4'd13,    1'b0, '0},
         '{OP_KEY,    KEY_NINE, 1'b0, '0},
         '{OP_KEY,    4'd10,    1'b0, '0},
         '{OP_KEY,    KEY_ONE,  1'b0, '0},
         '{OP_KEY,    4'd2,     1'b0, '0},
         '{OP_KEY,    KEY_HASH, 1'b1, '{ST_CONF_BAD, 5'd0, 3'd0, 8'd0, MODE_NEW}},
         '{OP_DELETE, KEY_ONE,  1'b1, '{ST_TAKEN,    5'd0, 3'd0, 8'd0, MODE_DELETE_ID}},
         '{OP_KEY,    4'd2,     1'b1, '{ST_IGNORED,  5'd0, 3'd0, 8'd0, MODE_DELETE_ID}},
         '{OP_KEY,    KEY_ONE,  1'b0, '0},
         '{OP_KEY,    KEY_NINE, 1'b1, '{ST_CLEARED,  SLOT_LAST, 3'd0, 8'd0, MODE_VERIFY}},
         '{OP_KEY,    4'd13,    1'b0, '0},
         '{OP_KEY,    4'd0,     1'b0, '0},
         '{OP_KEY,    KEY_STAR, 1'b0, '0},
         '{OP_KEY,    4'd0,     1'b0, '0},
         '{OP_KEY,    KEY_ONE,  1'b0, '0},
         '{OP_KEY,    4'd2,     1'b0, '0},
         '{OP_KEY,    4'd3,     1'b0, '0},
         '{OP_KEY,    4'd4,     1'b1, '{ST_MISMATCH, 5'd0, 3'd0, 8'd1, MODE_VERIFY}}
      };
      cur_mode    = MODE_VERIFY;
      entry_sym   = '0;
      entry_cnt   = '0;
      pending_sym = '0;
      id_digit    = '0;
      slot_mark   = '0;
      fail_cnt    = '0;
      foreach (slot_code[i]) slot_code[i] = '0;
      foreach (status_hits[i]) status_hits[i] = 0;
      req_chan.valid     <= 1'b0;
      req_chan.operation <= OP_KEY;
      req_chan.key_code  <= '0;
      reset = 1'b1;
      repeat (12) @(negedge clock);
      reset <= 1'b0;

      foreach (key_rows[i]) send(key_rows[i].op, key_rows[i].key, key_rows[i].typed,
                                 key_rows[i].res);
      drain();

      for (int p = 0; p < 4; p++) begin
         gap_pct   = gap_tab[p];
         stall_pct = stall_tab[p];
         n_counted = 0;
         while (n_counted < PHASE_ITEMS) run_flow();
         drain();
      end

      // a few mixed flows under light pressure on both sides
      gap_pct   = 10;
      stall_pct = 10;
      repeat (12) run_flow();

      stall_pct = 0;
      drain();
      repeat (40) @(posedge clock);

      $display("summary: %0d items accepted, %0d results checked, %0d bad fields",
               n_items, n_checked, n_fail);
      $display("summary: %0d matches, %0d stores, %0d clears, error count ended at %0d",
               status_hits[ST_MATCH], status_hits[ST_STORED], status_hits[ST_CLEARED],
               fail_cnt);
      if (n_fail == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
